// ===== hdl/npt_pkg.sv =====
package npt_pkg;

   localparam int INDEX_WIDTH     = 11;
   localparam int PRIME_OUT_WIDTH = 16;
   localparam int STEP_WIDTH      = 5;

   localparam int SEED_PRIME_0 = 2;
   localparam int SEED_PRIME_1 = 3;
   localparam int SEED_PRIME_2 = 5;
   localparam int SEED_COUNT   = 3;

   typedef logic [STEP_WIDTH-1:0] step_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_SEED0,
      OP_SEED1,
      OP_SEED2,
      OP_ACCEPT,
      OP_CAND_INIT,
      OP_TRIAL_INIT,
      OP_READ_IDX,
      OP_SQUARE,
      OP_DIV_START,
      OP_IDX_INC,
      OP_CAND_ADD2,
      OP_APPEND,
      OP_READ_HIT,
      OP_READ_MISS,
      OP_EMIT
   } op_type;

   typedef enum logic [3:0] {
      C_ALWAYS,
      C_REQ_VALID,
      C_ZERO,
      C_COVERED,
      C_OVERFLOW,
      C_IDX_END,
      C_SQ_GT,
      C_DIV_BUSY,
      C_DIVISIBLE,
      C_RSP_BUSY
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      logic     jump_if;
      step_type target;
   } ctl_word_type;

   typedef struct packed {
      logic req_valid;
      logic zero;
      logic covered;
      logic overflow;
      logic idx_end;
      logic sq_gt;
      logic div_busy;
      logic divisible;
      logic rsp_busy;
   } cond_flags_type;

   localparam step_type ST_INIT0  = 5'd0;
   localparam step_type ST_INIT1  = 5'd1;
   localparam step_type ST_INIT2  = 5'd2;
   localparam step_type ST_IDLE   = 5'd3;
   localparam step_type ST_CHKZ   = 5'd4;
   localparam step_type ST_CHKHIT = 5'd5;
   localparam step_type ST_EXTEND = 5'd6;
   localparam step_type ST_CINIT  = 5'd7;
   localparam step_type ST_CHECK  = 5'd8;
   localparam step_type ST_TRIAL  = 5'd9;
   localparam step_type ST_SQUARE = 5'd10;
   localparam step_type ST_SQTEST = 5'd11;
   localparam step_type ST_DIVGO  = 5'd12;
   localparam step_type ST_DIVWT  = 5'd13;
   localparam step_type ST_DIVTST = 5'd14;
   localparam step_type ST_LOOP   = 5'd15;
   localparam step_type ST_NEXT   = 5'd16;
   localparam step_type ST_APPEND = 5'd17;
   localparam step_type ST_RDMISS = 5'd18;
   localparam step_type ST_RDHIT  = 5'd19;
   localparam step_type ST_EMIT   = 5'd20;
   localparam step_type ST_DONE   = 5'd21;

   function automatic ctl_word_type make_word(input op_type op, input cond_type cond,
                                              input logic jump_if, input step_type target);
      ctl_word_type w;
      w.op      = op;
      w.cond    = cond;
      w.jump_if = jump_if;
      w.target  = target;
      return w;
   endfunction

   function automatic ctl_word_type ucode_word(input step_type step);
      ctl_word_type w;
      case (step)
         ST_INIT0:  w = make_word(OP_SEED0,      C_ALWAYS,    1'b0, ST_IDLE);
         ST_INIT1:  w = make_word(OP_SEED1,      C_ALWAYS,    1'b0, ST_IDLE);
         ST_INIT2:  w = make_word(OP_SEED2,      C_ALWAYS,    1'b0, ST_IDLE);
         ST_IDLE:   w = make_word(OP_ACCEPT,     C_REQ_VALID, 1'b0, ST_IDLE);
         ST_CHKZ:   w = make_word(OP_NOP,        C_ZERO,      1'b1, ST_EMIT);
         ST_CHKHIT: w = make_word(OP_NOP,        C_COVERED,   1'b1, ST_RDHIT);
         ST_EXTEND: w = make_word(OP_NOP,        C_COVERED,   1'b1, ST_RDMISS);
         ST_CINIT:  w = make_word(OP_CAND_INIT,  C_ALWAYS,    1'b0, ST_IDLE);
         ST_CHECK:  w = make_word(OP_TRIAL_INIT, C_OVERFLOW,  1'b1, ST_RDMISS);
         ST_TRIAL:  w = make_word(OP_READ_IDX,   C_IDX_END,   1'b1, ST_APPEND);
         ST_SQUARE: w = make_word(OP_SQUARE,     C_ALWAYS,    1'b0, ST_IDLE);
         ST_SQTEST: w = make_word(OP_NOP,        C_SQ_GT,     1'b1, ST_APPEND);
         ST_DIVGO:  w = make_word(OP_DIV_START,  C_ALWAYS,    1'b0, ST_IDLE);
         ST_DIVWT:  w = make_word(OP_NOP,        C_DIV_BUSY,  1'b1, ST_DIVWT);
         ST_DIVTST: w = make_word(OP_IDX_INC,    C_DIVISIBLE, 1'b1, ST_NEXT);
         ST_LOOP:   w = make_word(OP_NOP,        C_ALWAYS,    1'b1, ST_TRIAL);
         ST_NEXT:   w = make_word(OP_CAND_ADD2,  C_ALWAYS,    1'b1, ST_CHECK);
         ST_APPEND: w = make_word(OP_APPEND,     C_ALWAYS,    1'b1, ST_EXTEND);
         ST_RDMISS: w = make_word(OP_READ_MISS,  C_ALWAYS,    1'b1, ST_EMIT);
         ST_RDHIT:  w = make_word(OP_READ_HIT,   C_ALWAYS,    1'b0, ST_IDLE);
         ST_EMIT:   w = make_word(OP_EMIT,       C_RSP_BUSY,  1'b1, ST_EMIT);
         ST_DONE:   w = make_word(OP_NOP,        C_ALWAYS,    1'b1, ST_IDLE);
         default:   w = make_word(OP_NOP,        C_ALWAYS,    1'b1, ST_IDLE);
      endcase
      return w;
   endfunction

endpackage

// ===== hdl/nth_prime_table_generator.sv =====
// Answers requests for the n-th prime (n counted from one) from a table of primes that
// grows on demand. Right after reset the block writes the seeds 2, 3 and 5 into the
// table and accepts no beat meanwhile. A request whose index is already covered by the
// table is answered with from_table set; index zero is rejected with status set.
// A request beyond the table extends it one prime at a time: every candidate is tested
// against the stored primes whose square does not exceed it, and each such test is
// paced by the one-bit-per-cycle remainder unit and the single read port of the table;
// the time to answer therefore depends on how many primes must be added. Indices above
// TABLE_DEPTH are served as TABLE_DEPTH. One request is in work at a time; a finished
// result waits in the output register while the next request is taken.
module nth_prime_table_generator #(
   parameter int TABLE_DEPTH = 1024,
   parameter int PRIME_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [npt_pkg::INDEX_WIDTH-1:0]       req_wanted_index,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [npt_pkg::PRIME_OUT_WIDTH-1:0]   rsp_prime_value,
   output logic                                  rsp_from_table,
   output logic                                  rsp_status
);

   import npt_pkg::*;

   localparam int AW   = $clog2(TABLE_DEPTH);
   localparam int CW   = $clog2(TABLE_DEPTH + 1);
   localparam int CMPW = (CW > INDEX_WIDTH) ? CW : INDEX_WIDTH;
   localparam int SQW  = 2 * PRIME_WIDTH;

   ctl_word_type   ctl;
   cond_flags_type flags;

   logic [PRIME_WIDTH-1:0] table_mem [TABLE_DEPTH];

   logic [CW-1:0]          count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]          want_ff, want_in;
   logic                   zero_ff, zero_in;
   logic                   hit_ff, hit_in;
   logic [PRIME_WIDTH:0]   cand_ff, cand_in;
   logic [PRIME_WIDTH-1:0] last_ff, last_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic [SQW-1:0]         sq_ff, sq_in;
   logic [PRIME_WIDTH-1:0] rd_data_ff;
   logic [PRIME_OUT_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                   rsp_from_table_ff, rsp_from_table_in;
   logic                   rsp_status_ff, rsp_status_in;

   logic                   accept;
   logic                   rsp_busy;
   logic                   emit;
   logic                   covered;
   logic [CMPW-1:0]        index_ext;
   logic [CMPW-1:0]        depth_ext;
   logic [CMPW-1:0]        index_sat;
   logic [CW-1:0]          pick_pos;
   logic [CW-1:0]          pick_addr;

   logic                   mem_wr_en;
   logic [AW-1:0]          mem_wr_addr;
   logic [PRIME_WIDTH-1:0] mem_wr_data;
   logic                   mem_rd_en;
   logic [AW-1:0]          mem_rd_addr;

   logic                   div_start;
   logic                   div_busy;
   logic                   div_rem_zero;

   npt_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctl   (ctl)
   );

   npt_remainder #(
      .WIDTH (PRIME_WIDTH)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cand_ff[PRIME_WIDTH-1:0]),
      .divisor  (rd_data_ff),
      .busy     (div_busy),
      .rem_zero (div_rem_zero)
   );

   assign req_stall = (ctl.op != OP_ACCEPT);
   assign accept    = req_valid && (ctl.op == OP_ACCEPT);
   assign rsp_busy  = rsp_valid_ff && rsp_stall;
   assign emit      = (ctl.op == OP_EMIT) && !rsp_busy;
   assign div_start = (ctl.op == OP_DIV_START);
   assign covered   = (want_ff <= count_ff);

   assign index_ext = CMPW'(req_wanted_index);
   assign depth_ext = CMPW'(TABLE_DEPTH);
   assign index_sat = (index_ext > depth_ext) ? depth_ext : index_ext;

   assign pick_pos  = covered ? want_ff : count_ff;
   assign pick_addr = pick_pos - 1'b1;

   assign flags.req_valid = req_valid;
   assign flags.zero      = zero_ff;
   assign flags.covered   = covered;
   assign flags.overflow  = cand_ff[PRIME_WIDTH];
   assign flags.idx_end   = (idx_ff >= count_ff);
   assign flags.sq_gt     = (sq_ff > SQW'(cand_ff));
   assign flags.div_busy  = div_busy;
   assign flags.divisible = div_rem_zero;
   assign flags.rsp_busy  = rsp_busy;

   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = cand_ff[PRIME_WIDTH-1:0];
      mem_rd_en   = 1'b0;
      mem_rd_addr = pick_addr[AW-1:0];
      case (ctl.op)
         OP_SEED0: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = AW'(0);
            mem_wr_data = PRIME_WIDTH'(SEED_PRIME_0);
         end
         OP_SEED1: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = AW'(1);
            mem_wr_data = PRIME_WIDTH'(SEED_PRIME_1);
         end
         OP_SEED2: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = AW'(2);
            mem_wr_data = PRIME_WIDTH'(SEED_PRIME_2);
         end
         OP_APPEND: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = count_ff[AW-1:0];
         end
         OP_READ_IDX: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = idx_ff[AW-1:0];
         end
         OP_READ_HIT, OP_READ_MISS: begin
            mem_rd_en   = 1'b1;
         end
         default: begin
            mem_wr_en   = 1'b0;
         end
      endcase
   end

   always_comb begin
      count_in          = count_ff;
      want_in           = want_ff;
      zero_in           = zero_ff;
      hit_in            = hit_ff;
      cand_in           = cand_ff;
      last_in           = last_ff;
      idx_in            = idx_ff;
      sq_in             = sq_ff;
      rsp_value_in      = rsp_value_ff;
      rsp_from_table_in = rsp_from_table_ff;
      rsp_status_in     = rsp_status_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      case (ctl.op)
         OP_SEED2: begin
            last_in = PRIME_WIDTH'(SEED_PRIME_2);
         end
         OP_ACCEPT: begin
            if (accept) begin
               zero_in = (req_wanted_index == '0);
               want_in = CW'(index_sat);
            end
         end
         OP_CAND_INIT: begin
            cand_in = {1'b0, last_ff} + (PRIME_WIDTH + 1)'(2);
         end
         OP_CAND_ADD2: begin
            cand_in = cand_ff + (PRIME_WIDTH + 1)'(2);
         end
         OP_TRIAL_INIT: begin
            idx_in = '0;
         end
         OP_IDX_INC: begin
            idx_in = idx_ff + 1'b1;
         end
         OP_SQUARE: begin
            sq_in = {{PRIME_WIDTH{1'b0}}, rd_data_ff} * {{PRIME_WIDTH{1'b0}}, rd_data_ff};
         end
         OP_APPEND: begin
            count_in = count_ff + 1'b1;
            last_in  = cand_ff[PRIME_WIDTH-1:0];
         end
         OP_READ_HIT: begin
            hit_in = 1'b1;
         end
         OP_READ_MISS: begin
            hit_in = 1'b0;
         end
         OP_EMIT: begin
            if (emit) begin
               rsp_valid_in      = 1'b1;
               rsp_value_in      = zero_ff ? '0 : PRIME_OUT_WIDTH'(rd_data_ff);
               rsp_from_table_in = hit_ff && !zero_ff;
               rsp_status_in     = zero_ff;
            end
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         table_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= table_mem[mem_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= CW'(SEED_COUNT);
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      want_ff           <= want_in;
      zero_ff           <= zero_in;
      hit_ff            <= hit_in;
      cand_ff           <= cand_in;
      last_ff           <= last_in;
      idx_ff            <= idx_in;
      sq_ff             <= sq_in;
      rsp_value_ff      <= rsp_value_in;
      rsp_from_table_ff <= rsp_from_table_in;
      rsp_status_ff     <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prime_value = rsp_value_ff;
   assign rsp_from_table  = rsp_from_table_ff;
   assign rsp_status      = rsp_status_ff;

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctl.op == OP_EMIT))
      else $error("Result beat raised outside the emit step.");

   assert property (@(posedge clock) disable iff (reset)
      ctl.op == OP_APPEND |-> count_ff < want_ff)
      else $error("Table extended beyond the requested index.");

   assert property (@(posedge clock) disable iff (reset)
      ctl.op == OP_DIV_START |-> !div_busy)
      else $error("Remainder unit restarted while busy.");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("Prime count exceeds the table depth.");

endmodule

// ===== hdl/npt_remainder.sv =====
module npt_remainder #(
   parameter int WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             busy,
   output logic             rem_zero
);

   localparam int CNTW = $clog2(WIDTH + 1);

   logic             busy_ff, busy_in;
   logic [CNTW-1:0]  cnt_ff, cnt_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] dvd_ff, dvd_in;
   logic [WIDTH-1:0] dsr_ff, dsr_in;
   logic [WIDTH:0]   shifted;
   logic [WIDTH:0]   diff;

   assign shifted = {rem_ff, dvd_ff[WIDTH-1]};
   assign diff    = shifted - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNTW'(WIDTH);
         rem_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dsr_ff}) begin
            rem_in = diff[WIDTH-1:0];
         end else begin
            rem_in = shifted[WIDTH-1:0];
         end
         dvd_in  = {dvd_ff[WIDTH-2:0], 1'b0};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != CNTW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = busy_ff;
   assign rem_zero = (rem_ff == '0);

endmodule

// ===== hdl/npt_sequencer.sv =====
module npt_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  npt_pkg::cond_flags_type flags,
   output npt_pkg::ctl_word_type   ctl
);

   import npt_pkg::*;

   step_type     step_ff, step_in;
   ctl_word_type word;
   logic         cond_val;

   assign word = ucode_word(step_ff);

   always_comb begin
      case (word.cond)
         C_ALWAYS:    cond_val = 1'b1;
         C_REQ_VALID: cond_val = flags.req_valid;
         C_ZERO:      cond_val = flags.zero;
         C_COVERED:   cond_val = flags.covered;
         C_OVERFLOW:  cond_val = flags.overflow;
         C_IDX_END:   cond_val = flags.idx_end;
         C_SQ_GT:     cond_val = flags.sq_gt;
         C_DIV_BUSY:  cond_val = flags.div_busy;
         C_DIVISIBLE: cond_val = flags.divisible;
         C_RSP_BUSY:  cond_val = flags.rsp_busy;
         default:     cond_val = 1'b0;
      endcase
      if (cond_val == word.jump_if) begin
         step_in = word.target;
      end else begin
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_INIT0;
      end else begin
         step_ff <= step_in;
      end
   end

   assign ctl = word;

endmodule

// ===== tb/tb_nth_prime_table_generator.sv =====
`timescale 1ns / 100ps

module tb_nth_prime_table_generator;

   localparam int TABLE_DEPTH = 1024;
   localparam int PRIME_WIDTH = 16;
   localparam int PRIME_LIMIT = (1 << PRIME_WIDTH) - 1;
   localparam int RANDOM_ITEMS = 1530;
   localparam int MAX_REPORTS = 10;
   localparam int END_WAIT_CYCLES = 100;

   localparam logic STATUS_OK         = 1'b0;
   localparam logic STATUS_ZERO_INDEX = 1'b1;

   typedef struct packed {
      logic [npt_pkg::PRIME_OUT_WIDTH-1:0] prime;
      logic                                from_table;
      logic                                status;
   } prime_answer_type;

   typedef struct packed {
      logic                            drain_first;
      logic [npt_pkg::INDEX_WIDTH-1:0] index;
   } prime_request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [npt_pkg::INDEX_WIDTH-1:0] req_wanted_index = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [npt_pkg::PRIME_OUT_WIDTH-1:0] rsp_prime_value;
   logic rsp_from_table;
   logic rsp_status;

   prime_request_type pending_requests[$];
   prime_answer_type  awaited_answers[$];

   logic [PRIME_WIDTH-1:0] prime_store [0:TABLE_DEPTH-1];
   int stored_count;

   logic req_taken = 1'b0;
   int fail_count = 0;
   int burst_left = 1;
   int gap_left = 0;
   int stall_mode = 0;
   int stall_mode_left = 0;
   int stall_hold_left = 0;

   nth_prime_table_generator #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .PRIME_WIDTH(PRIME_WIDTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_wanted_index(req_wanted_index),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_prime_value(rsp_prime_value),
      .rsp_from_table(rsp_from_table),
      .rsp_status(rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic prime_answer_type lookup_nth_prime(
      input logic [npt_pkg::INDEX_WIDTH-1:0] wanted);
      prime_answer_type ans;
      int want;
      int cand;
      int k;
      bit composite;
      bit exhausted;
      ans = '0;
      ans.status = STATUS_OK;
      want = int'(wanted);
      if (want == 0) begin
         ans.status = STATUS_ZERO_INDEX;
         return ans;
      end
      if (want > TABLE_DEPTH) begin
         want = TABLE_DEPTH;
      end
      if (want <= stored_count) begin
         ans.from_table = 1'b1;
      end else begin
         exhausted = 1'b0;
         while (stored_count < want && !exhausted) begin
            cand = int'(prime_store[stored_count-1]);
            composite = 1'b1;
            while (composite && !exhausted) begin
               cand += 2;
               if (cand > PRIME_LIMIT) begin
                  exhausted = 1'b1;
               end else begin
                  composite = 1'b0;
                  k = 0;
                  while (k < stored_count && !composite &&
                         int'(prime_store[k]) * int'(prime_store[k]) <= cand) begin
                     if (cand % int'(prime_store[k]) == 0) begin
                        composite = 1'b1;
                     end
                     k++;
                  end
               end
            end
            if (!exhausted) begin
               prime_store[stored_count] = cand[PRIME_WIDTH-1:0];
               stored_count++;
            end
         end
         if (want > stored_count) begin
            want = stored_count;
         end
      end
      ans.prime = prime_store[want-1];
      return ans;
   endfunction

   always @(posedge clock) begin : watch_beats
      prime_answer_type want_ans;
      prime_answer_type got_ans;
      if (reset) begin
         req_taken <= 1'b0;
         prime_store[0] = PRIME_WIDTH'(npt_pkg::SEED_PRIME_0);
         prime_store[1] = PRIME_WIDTH'(npt_pkg::SEED_PRIME_1);
         prime_store[2] = PRIME_WIDTH'(npt_pkg::SEED_PRIME_2);
         stored_count = npt_pkg::SEED_COUNT;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            awaited_answers.push_back(lookup_nth_prime(req_wanted_index));
         end
         if (rsp_valid && !rsp_stall) begin
            got_ans.prime = rsp_prime_value;
            got_ans.from_table = rsp_from_table;
            got_ans.status = rsp_status;
            if (awaited_answers.size() == 0) begin
               if (fail_count < MAX_REPORTS) begin
                  $display("%0t: unexpected result beat prime=%0d from_table=%0b status=%0b",
                           $realtime, got_ans.prime, got_ans.from_table, got_ans.status);
               end
               fail_count++;
            end else begin
               want_ans = awaited_answers.pop_front();
               if (got_ans !== want_ans) begin
                  if (fail_count < MAX_REPORTS) begin
                     $display({"%0t: mismatch expected prime=%0d from_table=%0b status=%0b,",
                               " got prime=%0d from_table=%0b status=%0b"},
                              $realtime, want_ans.prime, want_ans.from_table, want_ans.status,
                              got_ans.prime, got_ans.from_table, got_ans.status);
                  end
                  fail_count++;
               end
            end
         end
      end
   end

   always @(negedge clock) begin : drive_requests
      logic next_valid;
      logic [npt_pkg::INDEX_WIDTH-1:0] next_index;
      prime_request_type head;
      next_valid = req_valid;
      next_index = req_wanted_index;
      if (reset) begin
         next_valid = 1'b0;
      end else if (req_valid && !req_taken) begin
         next_valid = 1'b1;
      end else begin
         next_valid = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_requests.size() > 0) begin
            head = pending_requests[0];
            if (!head.drain_first || awaited_answers.size() == 0) begin
               head = pending_requests.pop_front();
               next_valid = 1'b1;
               next_index = head.index;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
      req_valid <= next_valid;
      req_wanted_index <= next_index;
   end

   always @(negedge clock) begin : drive_stall
      logic next_stall;
      next_stall = 1'b0;
      if (!reset) begin
         if (stall_mode_left <= 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_mode_left = $urandom_range(20, 120);
         end
         stall_mode_left--;
         case (stall_mode)
            0: begin
               next_stall = 1'b0;
            end
            1: begin
               next_stall = ($urandom_range(0, 1) == 1);
            end
            2: begin
               next_stall = ($urandom_range(0, 3) == 0);
            end
            default: begin
               next_stall = rsp_stall;
               if (stall_hold_left <= 0) begin
                  next_stall = ~rsp_stall;
                  stall_hold_left = $urandom_range(1, 12);
               end
               stall_hold_left--;
            end
         endcase
      end
      rsp_stall <= next_stall;
   end

   task automatic queue_request(input int index, input bit drain_first);
      prime_request_type item;
      item.index = index[npt_pkg::INDEX_WIDTH-1:0];
      item.drain_first = drain_first;
      pending_requests.push_back(item);
   endtask

   initial begin : run_stimulus
      int directed[$];
      int tail[$];
      int grown;
      int idx;
      int r;
      int k;
      directed = {0, 1, 2, 3, 4, 4, 3, 0, 5, 8, 1, 6, 12, 11, 0, 20, 16, 2, 31, 32, 3, 0};
      tail = {1024, 1023, 1, 1025, 2047, 1536, 0, 1024, 2};
      foreach (directed[i]) begin
         queue_request(directed[i], 1'b0);
      end
      grown = 32;
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         r = $urandom_range(0, 99);
         if (grown < TABLE_DEPTH) begin
            if (r < 5) begin
               idx = 0;
            end else if (r < 70) begin
               idx = $urandom_range(1, grown);
            end else begin
               idx = grown + $urandom_range(1, 8);
               if (idx > TABLE_DEPTH) begin
                  idx = TABLE_DEPTH;
               end
               grown = idx;
            end
         end else if (r < 50) begin
            idx = $urandom_range(0, 2047);
         end else begin
            idx = $urandom_range(1, TABLE_DEPTH);
         end
         queue_request(idx, (k == 0) || (k == RANDOM_ITEMS / 2) || ($urandom_range(0, 49) == 0));
      end
      foreach (tail[i]) begin
         queue_request(tail[i], i == 0);
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (pending_requests.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      while (awaited_answers.size() != 0) begin
         @(posedge clock);
      end
      repeat (END_WAIT_CYCLES) @(posedge clock);
      if (fail_count == 0 && awaited_answers.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
